@@ hdl/wsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared types, codes and constants for the receive-side frame parser.
// ----------------------------------------------------------------------------
package wsfr_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SERVER_SIDE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENFORCE_LIMITS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_TYPE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_BYTES   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MESSAGE_BYTES = 3'd4;

   localparam logic [31:0] MAX_FRAME_RESET   = 32'd1048576;
   localparam logic [31:0] MAX_MESSAGE_RESET = 32'd4194304;

   // Stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_EMPTY_END = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   // Error codes
   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_RSV_BITS      = 4'd1;
   localparam logic [3:0] ERR_RSV_OPCODE    = 4'd2;
   localparam logic [3:0] ERR_MASKING       = 4'd3;
   localparam logic [3:0] ERR_CTRL_LARGE    = 4'd4;
   localparam logic [3:0] ERR_CTRL_FRAG     = 4'd5;
   localparam logic [3:0] ERR_NO_OPENING    = 4'd6;
   localparam logic [3:0] ERR_BAD_CONT      = 4'd7;
   localparam logic [3:0] ERR_WRONG_TYPE    = 4'd8;
   localparam logic [3:0] ERR_FRAME_LARGE   = 4'd9;
   localparam logic [3:0] ERR_MESSAGE_LARGE = 4'd10;

   // Opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Expected data type register values
   localparam logic [1:0] TYPE_TEXT   = 2'd1;
   localparam logic [1:0] TYPE_BINARY = 2'd2;

   // Seven-bit length codes
   localparam logic [6:0] CONTROL_MAX_PAYLOAD = 7'd125;
   localparam logic [6:0] LEN_CODE_16         = 7'd126;
   localparam logic [6:0] LEN_CODE_64         = 7'd127;

   localparam logic [3:0] EXT16_BYTES   = 4'd2;
   localparam logic [3:0] EXT64_BYTES   = 4'd8;
   localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

   typedef enum logic [4:0] {
      PH_HDR0 = 5'b00001,
      PH_HDR1 = 5'b00010,
      PH_LEN  = 5'b00100,
      PH_MASK = 5'b01000,
      PH_PAY  = 5'b10000
   } wsfr_phase_type;

   typedef struct packed {
      logic        server_side;
      logic        enforce_limits;
      logic [1:0]  expected_data_type;
      logic [31:0] max_frame_bytes;
      logic [31:0] max_message_bytes;
   } wsfr_cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [3:0] msg_opcode;
      logic       is_control;
      logic       frame_end;
      logic       message_end;
      logic       frame_valid;
      logic [3:0] error_code;
   } wsfr_item_type;

endpackage

@@ hdl/wsfr_parse.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame receiver parser
// Holds the frame and message state and turns one received byte into at most
// one result item per cycle.
// ----------------------------------------------------------------------------
module wsfr_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  logic [7:0]           in_byte,
   input  wsfr_pkg::wsfr_cfg_type cfg,
   output logic                 item_valid,
   output wsfr_pkg::wsfr_item_type item
);
   import wsfr_pkg::*;

   wsfr_phase_type phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        final_ff, final_in;
   logic        masked_ff, masked_in;
   logic [63:0] bytes_left_ff, bytes_left_in;
   logic [3:0]  len_left_ff, len_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_index_ff, mask_index_in;
   logic        bad_ff, bad_in;
   logic [3:0]  msg_opcode_ff, msg_opcode_in;
   logic        in_message_ff, in_message_in;
   logic [31:0] msg_bytes_ff, msg_bytes_in;
   logic        close_ff, close_in;

   // Header byte one checks
   logic [6:0]  len7;
   logic        ctl;
   logic [3:0]  hdr1_err;
   logic        hdr1_bad;
   logic        hdr1_open;

   // Length-known evaluation, shared by header byte one and the last length byte
   logic [63:0] bl_shift;
   logic [63:0] lk_bl;
   logic [31:0] lk_mb;
   logic        lk_bad;
   logic [64:0] lk_sum;
   logic [31:0] lk_sat;
   logic        lk_too_big;
   logic [3:0]  lk_err;
   logic [31:0] lk_mb_new;

   logic [3:0]  raise_code;
   logic        bad_base;
   logic        raise;
   logic [3:0]  pending_err;
   logic        done;
   logic        have_data;
   logic [7:0]  pay_data;
   logic [7:0]  key;
   logic [3:0]  len_dec;
   logic [63:0] bl_dec;

   assign len7     = in_byte[6:0];
   assign ctl      = opcode_ff[3];
   assign bl_shift = {bytes_left_ff[55:0], in_byte};
   assign len_dec  = len_left_ff - 4'd1;
   assign bl_dec   = (bytes_left_ff != 64'd0) ? bytes_left_ff - 64'd1 : 64'd0;

   always_comb begin
      hdr1_err = ERR_NONE;
      if (!bad_ff) begin
         priority if (in_byte[7] != cfg.server_side) begin
            hdr1_err = ERR_MASKING;
         end else if (ctl && len7 > CONTROL_MAX_PAYLOAD) begin
            hdr1_err = ERR_CTRL_LARGE;
         end else if (ctl && !final_ff) begin
            hdr1_err = ERR_CTRL_FRAG;
         end else if (!in_message_ff && opcode_ff == OP_CONT) begin
            hdr1_err = ERR_NO_OPENING;
         end else if (in_message_ff && opcode_ff != OP_CONT && !ctl) begin
            hdr1_err = ERR_BAD_CONT;
         end else if (cfg.enforce_limits &&
                      (cfg.expected_data_type == TYPE_TEXT ||
                       cfg.expected_data_type == TYPE_BINARY) &&
                      (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY) &&
                      opcode_ff != {2'b00, cfg.expected_data_type}) begin
            hdr1_err = ERR_WRONG_TYPE;
         end
      end
      hdr1_bad  = bad_ff || (hdr1_err != ERR_NONE);
      hdr1_open = !hdr1_bad && !final_ff && (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY);
   end

   always_comb begin
      if (phase_ff == PH_LEN) begin
         lk_bl  = bl_shift;
         lk_mb  = msg_bytes_ff;
         lk_bad = bad_ff;
      end else begin
         lk_bl  = {57'd0, len7};
         lk_mb  = hdr1_open ? 32'd0 : msg_bytes_ff;
         lk_bad = hdr1_bad;
      end
      lk_sum     = {33'd0, lk_mb} + {1'b0, lk_bl};
      lk_sat     = (lk_sum[64:32] != 33'd0) ? 32'hFFFF_FFFF : lk_sum[31:0];
      lk_too_big = (lk_bl[63:32] != 32'd0) || (lk_bl[31:0] > cfg.max_frame_bytes);
      lk_err     = ERR_NONE;
      lk_mb_new  = lk_mb;
      if (!lk_bad && cfg.enforce_limits && lk_too_big) begin
         lk_err = ERR_FRAME_LARGE;
      end else if (!lk_bad && !ctl) begin
         lk_mb_new = lk_sat;
         if (cfg.enforce_limits && lk_sat > cfg.max_message_bytes) begin
            lk_err = ERR_MESSAGE_LARGE;
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      opcode_in     = opcode_ff;
      final_in      = final_ff;
      masked_in     = masked_ff;
      bytes_left_in = bytes_left_ff;
      len_left_in   = len_left_ff;
      mask_key_in   = mask_key_ff;
      mask_index_in = mask_index_ff;
      msg_opcode_in = msg_opcode_ff;
      in_message_in = in_message_ff;
      msg_bytes_in  = msg_bytes_ff;
      raise_code    = ERR_NONE;
      bad_base      = bad_ff;
      done          = 1'b0;
      have_data     = 1'b0;
      key           = 8'd0;
      pay_data      = 8'd0;

      unique case (phase_ff)
         PH_HDR1: begin
            masked_in  = in_byte[7];
            raise_code = hdr1_err;
            if (hdr1_open) begin
               in_message_in = 1'b1;
               msg_opcode_in = opcode_ff;
               msg_bytes_in  = 32'd0;
            end
            bytes_left_in = 64'd0;
            if (len7 == LEN_CODE_16) begin
               phase_in    = PH_LEN;
               len_left_in = EXT16_BYTES;
            end else if (len7 == LEN_CODE_64) begin
               phase_in    = PH_LEN;
               len_left_in = EXT64_BYTES;
            end else begin
               bytes_left_in = lk_bl;
               if (hdr1_err == ERR_NONE) begin
                  raise_code = lk_err;
               end
               msg_bytes_in  = lk_mb_new;
               mask_index_in = 2'd0;
               if (in_byte[7]) begin
                  phase_in    = PH_MASK;
                  len_left_in = MASK_KEY_BYTES;
               end else if (lk_bl == 64'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_LEN: begin
            bytes_left_in = bl_shift;
            len_left_in   = len_dec;
            if (len_dec == 4'd0) begin
               raise_code    = lk_err;
               msg_bytes_in  = lk_mb_new;
               mask_index_in = 2'd0;
               if (masked_ff) begin
                  phase_in    = PH_MASK;
                  len_left_in = MASK_KEY_BYTES;
               end else if (bl_shift == 64'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_MASK: begin
            mask_key_in = {mask_key_ff[23:0], in_byte};
            len_left_in = len_dec;
            if (len_dec == 4'd0) begin
               mask_index_in = 2'd0;
               if (bytes_left_ff == 64'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            if (masked_ff) begin
               unique case (mask_index_ff)
                  2'd0: key = mask_key_ff[31:24];
                  2'd1: key = mask_key_ff[23:16];
                  2'd2: key = mask_key_ff[15:8];
                  default: key = mask_key_ff[7:0];
               endcase
            end
            mask_index_in = mask_index_ff + 2'd1;
            pay_data      = in_byte ^ key;
            have_data     = !bad_ff;
            bytes_left_in = bl_dec;
            done          = (bl_dec == 64'd0);
         end
         default: begin
            // Header byte zero; unused phase codes land here as well.
            final_in      = in_byte[7];
            opcode_in     = in_byte[3:0];
            bad_base      = 1'b0;
            masked_in     = 1'b0;
            bytes_left_in = 64'd0;
            mask_index_in = 2'd0;
            if (in_byte[6:4] != 3'd0) begin
               raise_code = ERR_RSV_BITS;
            end else if (!(in_byte[3:0] <= OP_BINARY ||
                           (in_byte[3:0] >= OP_CLOSE && in_byte[3:0] <= OP_PONG))) begin
               raise_code = ERR_RSV_OPCODE;
            end
            phase_in = PH_HDR1;
         end
      endcase

      raise       = (raise_code != ERR_NONE);
      bad_in      = bad_base || raise;
      pending_err = (raise && !close_ff) ? raise_code : ERR_NONE;
      close_in    = close_ff || raise || (done && !bad_in && opcode_in == OP_CLOSE);

      item.kind        = KIND_EMPTY_END;
      item.data        = 8'd0;
      item.msg_opcode  = (opcode_in == OP_CONT) ? msg_opcode_in : opcode_in;
      item.is_control  = opcode_in[3];
      item.frame_end   = done;
      item.message_end = done && final_in;
      item.frame_valid = 1'b1;
      item.error_code  = ERR_NONE;
      if (pending_err != ERR_NONE) begin
         item.kind        = KIND_ERROR;
         item.frame_valid = 1'b0;
         item.error_code  = pending_err;
      end else if (have_data) begin
         item.kind = KIND_PAYLOAD;
         item.data = pay_data;
      end
      item_valid = (pending_err != ERR_NONE) || have_data || (done && !bad_in);

      if (done) begin
         if (!opcode_in[3] && final_in) begin
            in_message_in = 1'b0;
            msg_bytes_in  = 32'd0;
         end
         phase_in = PH_HDR0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         opcode_ff     <= OP_CONT;
         final_ff      <= 1'b0;
         masked_ff     <= 1'b0;
         bytes_left_ff <= 64'd0;
         len_left_ff   <= 4'd0;
         mask_key_ff   <= 32'd0;
         mask_index_ff <= 2'd0;
         bad_ff        <= 1'b0;
         msg_opcode_ff <= OP_CONT;
         in_message_ff <= 1'b0;
         msg_bytes_ff  <= 32'd0;
         close_ff      <= 1'b0;
      end else if (byte_accept) begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         final_ff      <= final_in;
         masked_ff     <= masked_in;
         bytes_left_ff <= bytes_left_in;
         len_left_ff   <= len_left_in;
         mask_key_ff   <= mask_key_in;
         mask_index_ff <= mask_index_in;
         bad_ff        <= bad_in;
         msg_opcode_ff <= msg_opcode_in;
         in_message_ff <= in_message_in;
         msg_bytes_ff  <= msg_bytes_in;
         close_ff      <= close_in;
      end
   end

endmodule

@@ hdl/wsfr_out_queue.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame receiver result queue
// Two-entry result buffer that decouples the parser from downstream stalls.
// ----------------------------------------------------------------------------
module wsfr_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wsfr_pkg::wsfr_item_type push_item,
   output logic                    can_push,
   output logic                    head_valid,
   output wsfr_pkg::wsfr_item_type head_item,
   input  logic                    pop
);
   import wsfr_pkg::*;

   wsfr_item_type slot0_ff, slot0_in;
   wsfr_item_type slot1_ff, slot1_in;
   logic [1:0]    count_ff, count_in;
   logic          do_pop;

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot0_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case ({push, do_pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_item;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_item;
            end
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_item;
            end else begin
               slot1_in = push_item;
            end
            count_in = count_ff + 2'd1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ hdl/websocket_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Receive-side frame parser: header decode, length and mask key capture,
// payload unmasking and protocol checks, one received byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Content
//  req_      in         req_tvalid/tready     one received byte per transfer
//  rsp_      out        rsp_tvalid/tready     payload byte, empty frame end or
//                                             error notice per transfer
//  csr_      in         csr_valid/csr_ready   register index and write data
//
//  A byte is taken in every cycle while the result queue has room; its full
//  state update and its result are ready at the next edge.
//  Throughput is one byte per cycle while the result queue has room; the parser
//  updates its whole state as each byte is taken. The two-entry result queue
//  takes one more result while the result side stalls; req_tready drops only
//  when both entries are full, so in steady streaming the input stalls with it.
//  Reset is synchronous and active high; it restores the register defaults
//  and returns the parser to header byte zero with no open message.
//
module websocket_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input bytes. tdata: [7:0] in_byte
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wsfr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Results. tdata: [7:0] data, [11:8] msg_opcode, [12] message_end,
   // [13] frame_valid, [17:14] error_code, [23:18] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wsfr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: [1:0] kind, [2] is_control
   output logic [wsfr_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   // tlast: frame_end
   output logic                                 rsp_tlast,
   // Configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wsfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wsfr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import wsfr_pkg::*;

   wsfr_cfg_type  cfg_ff, cfg_in;
   logic          byte_accept;
   logic          item_valid;
   wsfr_item_type item;
   logic          can_push;
   wsfr_item_type head_item;

   // Configuration registers: writes are always taken; indexes past the
   // register list are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SERVER_SIDE:       cfg_in.server_side        = csr_data[0];
            CSR_ENFORCE_LIMITS:    cfg_in.enforce_limits     = csr_data[0];
            CSR_EXPECTED_TYPE:     cfg_in.expected_data_type = csr_data[1:0];
            CSR_MAX_FRAME_BYTES:   cfg_in.max_frame_bytes    = csr_data;
            CSR_MAX_MESSAGE_BYTES: cfg_in.max_message_bytes  = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_side        <= 1'b1;
         cfg_ff.enforce_limits     <= 1'b1;
         cfg_ff.expected_data_type <= 2'd0;
         cfg_ff.max_frame_bytes    <= MAX_FRAME_RESET;
         cfg_ff.max_message_bytes  <= MAX_MESSAGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A byte transfer happens whenever the queue can take a possible result.
   assign req_tready  = can_push;
   assign byte_accept = req_tvalid && req_tready;

   wsfr_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .in_byte     (req_tdata[7:0]),
      .cfg         (cfg_ff),
      .item_valid  (item_valid),
      .item        (item)
   );

   wsfr_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (byte_accept && item_valid),
      .push_item  (item),
      .can_push   (can_push),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .pop        (rsp_tready)
   );

   // Output packing, highest field first.
   assign rsp_tdata = {6'd0, head_item.error_code, head_item.frame_valid,
                       head_item.message_end, head_item.msg_opcode, head_item.data};
   assign rsp_tuser = {head_item.is_control, head_item.kind};
   assign rsp_tlast = head_item.frame_end;

endmodule

@@ hdl/wsfr_checker.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame receiver checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wsfr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wsfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [wsfr_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);
   import wsfr_pkg::*;

   // A stalled result holds its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Error notices carry a code and are never marked valid.
   a_err_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_ERROR |->
      !rsp_tdata[13] && rsp_tdata[17:14] != ERR_NONE && rsp_tdata[7:0] == 8'd0)
      else $error("malformed error notice");

   // Non-error results are valid, carry no code and use a defined kind.
   a_good_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != KIND_ERROR |->
      rsp_tdata[13] && rsp_tdata[17:14] == ERR_NONE &&
      (rsp_tuser[1:0] == KIND_PAYLOAD || rsp_tuser[1:0] == KIND_EMPTY_END))
      else $error("malformed data result");

   // An empty frame end always closes its frame.
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_EMPTY_END |-> rsp_tlast &&
      rsp_tdata[7:0] == 8'd0)
      else $error("empty frame end without frame end mark");

   // Message end is only flagged on the last item of a frame.
   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tlast)
      else $error("message end without frame end");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (.*);

@@ verif/wsfr_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver stream checker
// Watches the byte, result and register channels of the frame receiver,
// re-parses every accepted byte with its own copy of the parser state and
// compares each result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module wsfr_stream_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [wsfr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [wsfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [wsfr_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [wsfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wsfr_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      results_checked,
   output int unsigned                      items_due
);
   import wsfr_pkg::*;

   typedef enum logic [2:0] {
      RX_HEADER0, RX_HEADER1, RX_EXTLEN, RX_MASKKEY, RX_PAYLOAD
   } rx_step_type;

   // Register copy
   logic        cfg_server;
   logic        cfg_enforce;
   logic [1:0]  cfg_type;
   logic [31:0] cfg_max_frame;
   logic [31:0] cfg_max_msg;

   // Parser copy
   rx_step_type step;
   logic [3:0]  f_op;
   logic        f_fin;
   logic        f_masked;
   logic        f_bad;
   logic [63:0] remaining;
   logic [3:0]  hdr_count;
   logic [31:0] key;
   logic [1:0]  key_idx;
   logic [3:0]  m_op;
   logic        m_open;
   logic [31:0] m_count;
   logic        closing;

   // Per-byte scratch
   logic [3:0]  err_note;
   logic        done;

   wsfr_item_type rx_items_due[$];

   function automatic void mark_frame_bad(input logic [3:0] code);
      if (f_bad) return;
      f_bad = 1'b1;
      if (!closing) err_note = code;
      closing = 1'b1;
   endfunction

   // The payload length is complete: apply size limits, count message bytes and pick the next step.
   function automatic void finish_length();
      logic [64:0] sum;
      if (!f_bad && cfg_enforce && remaining > {32'd0, cfg_max_frame})
         mark_frame_bad(ERR_FRAME_LARGE);
      if (!f_bad && !f_op[3]) begin
         sum = {33'd0, m_count} + {1'b0, remaining};
         m_count = (sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         if (cfg_enforce && m_count > cfg_max_msg) mark_frame_bad(ERR_MESSAGE_LARGE);
      end
      key_idx = '0;
      if (f_masked) begin
         step      = RX_MASKKEY;
         hdr_count = MASK_KEY_BYTES;
      end else if (remaining == 0) begin
         done = 1'b1;
      end else begin
         step = RX_PAYLOAD;
      end
   endfunction

   function automatic void decode_length_byte(input logic [7:0] b);
      logic [6:0] len7;
      logic       ctl;
      len7     = b[6:0];
      ctl      = f_op[3];
      f_masked = b[7];
      if (!f_bad) begin
         if (f_masked != cfg_server) mark_frame_bad(ERR_MASKING);
         else if (ctl && len7 > CONTROL_MAX_PAYLOAD) mark_frame_bad(ERR_CTRL_LARGE);
         else if (ctl && !f_fin) mark_frame_bad(ERR_CTRL_FRAG);
         else if (!m_open && f_op == OP_CONT) mark_frame_bad(ERR_NO_OPENING);
         else if (m_open && f_op != OP_CONT && !ctl) mark_frame_bad(ERR_BAD_CONT);
         else if (cfg_enforce && (cfg_type == TYPE_TEXT || cfg_type == TYPE_BINARY) &&
                  (f_op == OP_TEXT || f_op == OP_BINARY) && f_op != {2'b00, cfg_type})
            mark_frame_bad(ERR_WRONG_TYPE);
      end
      if (!f_bad && !f_fin && (f_op == OP_TEXT || f_op == OP_BINARY)) begin
         m_open  = 1'b1;
         m_op    = f_op;
         m_count = '0;
      end
      remaining = '0;
      if (len7 == LEN_CODE_16) begin
         step      = RX_EXTLEN;
         hdr_count = EXT16_BYTES;
      end else if (len7 == LEN_CODE_64) begin
         step      = RX_EXTLEN;
         hdr_count = EXT64_BYTES;
      end else begin
         remaining = {57'd0, len7};
         finish_length();
      end
   endfunction

   // Advances the parser copy by one byte; returns 1 when the byte yields a result.
   function automatic logic parse_byte(input logic [7:0] b, output wsfr_item_type res);
      logic       have_data;
      logic       valid_end;
      logic [7:0] plain;
      logic [7:0] key_byte;
      have_data = 1'b0;
      plain     = '0;
      err_note  = ERR_NONE;
      done      = 1'b0;
      case (step)
         RX_HEADER1: decode_length_byte(b);
         RX_EXTLEN: begin
            remaining = {remaining[55:0], b};
            hdr_count = hdr_count - 1'b1;
            if (hdr_count == 0) finish_length();
         end
         RX_MASKKEY: begin
            key       = {key[23:0], b};
            hdr_count = hdr_count - 1'b1;
            if (hdr_count == 0) begin
               key_idx = '0;
               if (remaining == 0) done = 1'b1;
               else step = RX_PAYLOAD;
            end
         end
         RX_PAYLOAD: begin
            key_byte  = f_masked ? 8'(key >> (24 - 8 * int'(key_idx))) : 8'd0;
            key_idx   = key_idx + 1'b1;
            plain     = b ^ key_byte;
            have_data = !f_bad;
            if (remaining != 0) remaining = remaining - 1'b1;
            if (remaining == 0) done = 1'b1;
         end
         default: begin
            f_fin     = b[7];
            f_op      = b[3:0];
            f_bad     = 1'b0;
            f_masked  = 1'b0;
            remaining = '0;
            key_idx   = '0;
            if (b[6:4] != 3'b000) mark_frame_bad(ERR_RSV_BITS);
            else if (!(f_op <= OP_BINARY || (f_op >= OP_CLOSE && f_op <= OP_PONG)))
               mark_frame_bad(ERR_RSV_OPCODE);
            step = RX_HEADER1;
         end
      endcase

      res             = '0;
      res.msg_opcode  = (f_op == OP_CONT) ? m_op : f_op;
      res.is_control  = f_op[3];
      res.frame_end   = done;
      res.message_end = done && f_fin;
      valid_end       = done && !f_bad;
      if (done) begin
         if (!f_op[3] && f_fin) begin
            m_open  = 1'b0;
            m_count = '0;
         end
         if (!f_bad && f_op == OP_CLOSE) closing = 1'b1;
         step = RX_HEADER0;
      end
      if (err_note != ERR_NONE) begin
         res.kind       = KIND_ERROR;
         res.error_code = err_note;
         return 1'b1;
      end
      if (have_data) begin
         res.kind        = KIND_PAYLOAD;
         res.data        = plain;
         res.frame_valid = 1'b1;
         return 1'b1;
      end
      if (valid_end) begin
         res.kind        = KIND_EMPTY_END;
         res.frame_valid = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic string item_text(input wsfr_item_type it);
      return $sformatf("kind %0d data %h op %h ctl %b fend %b mend %b valid %b err %0d",
                       it.kind, it.data, it.msg_opcode, it.is_control, it.frame_end,
                       it.message_end, it.frame_valid, it.error_code);
   endfunction

   function automatic void log_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, what);
   endfunction

   always @(posedge clock) begin : monitor
      wsfr_item_type want;
      wsfr_item_type got;
      if (reset) begin
         mismatch_count  = 0;
         results_checked = 0;
         cfg_server      = 1'b1;
         cfg_enforce     = 1'b1;
         cfg_type        = 2'd0;
         cfg_max_frame   = MAX_FRAME_RESET;
         cfg_max_msg     = MAX_MESSAGE_RESET;
         step            = RX_HEADER0;
         f_op            = '0;
         f_fin           = 1'b0;
         f_masked        = 1'b0;
         f_bad           = 1'b0;
         remaining       = '0;
         hdr_count       = '0;
         key             = '0;
         key_idx         = '0;
         m_op            = '0;
         m_open          = 1'b0;
         m_count         = '0;
         closing         = 1'b0;
         rx_items_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SERVER_SIDE:       cfg_server    = csr_data[0];
               CSR_ENFORCE_LIMITS:    cfg_enforce   = csr_data[0];
               CSR_EXPECTED_TYPE:     cfg_type      = csr_data[1:0];
               CSR_MAX_FRAME_BYTES:   cfg_max_frame = csr_data;
               CSR_MAX_MESSAGE_BYTES: cfg_max_msg   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (parse_byte(req_tdata[7:0], want)) rx_items_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind        = rsp_tuser[1:0];
            got.is_control  = rsp_tuser[2];
            got.frame_end   = rsp_tlast;
            got.data        = rsp_tdata[7:0];
            got.msg_opcode  = rsp_tdata[11:8];
            got.message_end = rsp_tdata[12];
            got.frame_valid = rsp_tdata[13];
            got.error_code  = rsp_tdata[17:14];
            results_checked++;
            if (rx_items_due.size() == 0) begin
               log_failure($sformatf("result with none expected: %s", item_text(got)));
            end else begin
               want = rx_items_due[0];
               rx_items_due.delete(0);
               if (got !== want || rsp_tdata[RSP_TDATA_W-1:18] !== '0)
                  log_failure($sformatf("result mismatch, tdata %h\n  expected %s\n  actual   %s",
                                        rsp_tdata, item_text(want), item_text(got)));
            end
         end
      end
      items_due <= rx_items_due.size();
   end

endmodule

@@ verif/tb_websocket_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Feeds the receiver complete frames, fragmented messages with interleaved
// control frames, and malformed frames under several register settings and
// idle patterns, while a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver;
   import wsfr_pkg::*;

   localparam int CLOCK_HIGH_NS    = 6;
   localparam int CLOCK_LOW_NS     = 6;
   localparam int RESET_CYCLES     = 3;
   // The block registers each result and buffers two of them, so DRAIN_CYCLES
   // is ample for it to settle once nothing is expected.
   localparam int DRAIN_CYCLES     = 8;
   localparam int HOLD_OFF_CYCLES  = 200;
   localparam int RUN_LIMIT_CYCLES = 200000;
   localparam int BYTES_PER_PHASE  = 230;

   // Codes the package does not name.
   localparam logic [3:0] OP_PING        = 4'h9;
   localparam logic [1:0] TYPE_ANY       = 2'd0;
   localparam logic [1:0] TYPE_UNCHECKED = 2'd3;

   typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   int unsigned mismatch_count;
   int unsigned results_checked;
   int unsigned items_due;

   // Stimulus knobs, written only by the stimulus process.
   int unsigned send_gap_pct  = 24;
   int unsigned recv_gap_pct  = 60;
   int unsigned hold_off_req  = 0;
   int unsigned bytes_sent    = 0;
   int unsigned frames_sent   = 0;
   int unsigned settings_used = 1;

   // What the generator believes the block is configured for, so that
   // well-formed frames honor the masking direction and data type.
   logic       srv_side = 1'b1;
   logic [1:0] exp_type = TYPE_ANY;

   // Receiver side state, owned by the ready process.
   int unsigned hold_off_seen = 0;
   int unsigned hold_left     = 0;

   websocket_frame_receiver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   wsfr_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked),
      .items_due       (items_due)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_LOW_NS);
      clock = 1'b1;
      #(CLOCK_HIGH_NS);
   end

   // Result side: random back-pressure, or a long hold-off when the stimulus
   // asks for one. The hold-off length is counted here, so the sender keeps
   // offering bytes until the block's result queue fills and it stops taking them.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_off_seen != hold_off_req) begin
         rsp_tready    <= 1'b0;
         hold_off_seen <= hold_off_req;
         hold_left     <= HOLD_OFF_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Watchdog: a run that has not finished by now is stuck.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Cycle limit reached with %0d results still awaited", items_due);
      $display("TB_ERROR");
      $finish;
   end

   // One byte transfer. The valid is only lowered while idling, so a byte
   // that follows straight on keeps it high.
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Sends a header, the length in the chosen encoding, an optional random
   // mask key and body_len random payload bytes. The declared length is
   // normally the body length; the control frames of send_control and the final open-ended frame differ.
   task automatic send_frame(input logic [7:0] head, input logic masked,
                             input logic [63:0] declared, input len_form_type form,
                             input int unsigned body_len);
      logic [6:0] len_code;
      if (form == LEN_SHORT && declared >= LEN_CODE_16) form = LEN_EXT16;
      case (form)
         LEN_SHORT: len_code = declared[6:0];
         LEN_EXT16: len_code = LEN_CODE_16;
         default:   len_code = LEN_CODE_64;
      endcase
      push_byte(head);
      push_byte({masked, len_code});
      if (form == LEN_EXT16) begin
         for (int i = 1; i >= 0; i--) push_byte(declared[8*i +: 8]);
      end else if (form == LEN_EXT64) begin
         for (int i = 7; i >= 0; i--) push_byte(declared[8*i +: 8]);
      end
      if (masked) repeat (4) push_byte(8'($urandom));
      repeat (body_len) push_byte(8'($urandom));
      frames_sent++;
   endtask

   // Mostly short payloads, now and then the longer encodings with small values.
   task automatic pick_length(output int unsigned len, output len_form_type form);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         len  = $urandom_range(100, 125);
         form = LEN_SHORT;
      end else if (roll < 85) begin
         len  = $urandom_range(0, 12);
         form = LEN_SHORT;
      end else if (roll < 95) begin
         len  = $urandom_range(0, 200);
         form = LEN_EXT16;
      end else begin
         len  = $urandom_range(0, 40);
         form = LEN_EXT64;
      end
   endtask

   task automatic send_control();
      int unsigned roll;
      logic [3:0]  op;
      roll = $urandom_range(0, 99);
      op   = (roll < 3) ? OP_CLOSE : (roll < 50) ? OP_PING : OP_PONG;
      send_frame({1'b1, 3'b000, op}, srv_side, 64'($urandom_range(0, 10)), LEN_SHORT, 0);
   endtask

   // A well-formed data message of one to three fragments, with control
   // frames now and then slipped in between the fragments.
   task automatic send_message();
      logic [3:0]   data_op;
      int unsigned  nfrag;
      int unsigned  len;
      len_form_type form;
      if (exp_type == TYPE_TEXT) data_op = OP_TEXT;
      else if (exp_type == TYPE_BINARY) data_op = OP_BINARY;
      else data_op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
      nfrag = $urandom_range(1, 3);
      for (int f = 0; f < nfrag; f++) begin
         if (f > 0 && $urandom_range(0, 99) < 30) send_control();
         pick_length(len, form);
         send_frame({f == nfrag - 1, 3'b000, (f == 0) ? data_op : OP_CONT},
                    srv_side, 64'(len), form, len);
      end
   endtask

   // Malformed frames and broken sequences.
   task automatic send_noise_frame();
      int unsigned  roll;
      int unsigned  len;
      len_form_type form;
      roll = $urandom_range(0, 99);
      pick_length(len, form);
      if (roll < 45) begin
         // Any header byte at all: reserved bits, reserved opcodes, either mask.
         send_frame(8'($urandom), 1'($urandom), 64'(len), form, len);
      end else if (roll < 60) begin
         send_frame({1'($urandom), 3'b000, OP_CONT}, srv_side, 64'(len), form, len);
      end else if (roll < 70) begin
         send_frame({1'b0, 3'b000, OP_PING}, srv_side, 64'(len % 10), LEN_SHORT, len % 10);
      end else if (roll < 78) begin
         len = $urandom_range(126, 140);
         send_frame({1'b1, 3'b000, OP_PONG}, srv_side, 64'(len), LEN_EXT16, len);
      end else if (roll < 88) begin
         send_frame({1'b1, 3'b000, OP_TEXT}, !srv_side, 64'(len), form, len);
      end else begin
         // A message is opened and then a fresh data frame cuts in.
         send_frame({1'b0, 3'b000, OP_BINARY}, srv_side, 64'(len % 8), LEN_SHORT, len % 8);
         send_frame({1'b1, 3'b000, OP_TEXT}, srv_side, 64'(len), form, len);
      end
   endtask

   // A final continuation frame ends any message left open by earlier noise.
   task automatic close_open_message();
      send_frame({1'b1, 3'b000, OP_CONT}, srv_side, 64'd0, LEN_SHORT, 0);
   endtask

   // Wait until every predicted result has come back and the block has had
   // time to finish any byte that produces no result.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do begin
         while (items_due != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (items_due != 0);
   endtask

   task automatic put_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_registers(input logic server, input logic enforce,
                                  input logic [1:0] dtype, input logic [31:0] max_frame,
                                  input logic [31:0] max_message);
      put_register(CSR_SERVER_SIDE, 32'(server));
      put_register(CSR_ENFORCE_LIMITS, 32'(enforce));
      put_register(CSR_EXPECTED_TYPE, 32'(dtype));
      put_register(CSR_MAX_FRAME_BYTES, max_frame);
      put_register(CSR_MAX_MESSAGE_BYTES, max_message);
      csr_valid <= 1'b0;
      srv_side  = server;
      exp_type  = dtype;
      settings_used++;
   endtask

   // One random phase: a new register setting and idle pattern, optionally a long hold-off frame,
   // then mostly well-formed messages with random content and a quarter of noise.
   task automatic run_phase(input logic server, input logic enforce, input logic [1:0] dtype,
                            input logic [31:0] max_frame, input logic [31:0] max_message,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input logic with_hold_off);
      int unsigned target;
      quiesce();
      write_registers(server, enforce, dtype, max_frame, max_message);
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      if (with_hold_off) begin
         // Let the result side stall for a long stretch while a long frame
         // keeps arriving, so the block's input has to stall too.
         close_open_message();
         hold_off_req++;
         send_frame({1'b1, 3'b000, OP_BINARY}, srv_side, 64'd150, LEN_EXT16, 150);
      end
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 99) < 75) send_message();
         else send_noise_frame();
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values (masked input, limits on).
      // An empty final text frame gives a lone frame-end result.
      send_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, 64'd0, LEN_SHORT, 0);
      // A text message split in two, with a ping in the middle; the closing
      // continuation uses the 16-bit length form and reports the text opcode.
      send_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, 64'd1, LEN_SHORT, 1);
      send_frame({1'b1, 3'b000, OP_PING}, 1'b1, 64'd1, LEN_SHORT, 1);
      send_frame({1'b1, 3'b000, OP_CONT}, 1'b1, 64'd1, LEN_EXT16, 1);
      // All three reserved bits set: the first error of the connection, so
      // it is reported on the first header byte before the frame ends.
      send_frame({1'b1, 3'b111, OP_BINARY}, 1'b0, 64'd0, LEN_SHORT, 0);

      run_phase(1'b1, 1'b1, TYPE_UNCHECKED, MAX_FRAME_RESET, MAX_MESSAGE_RESET, 24, 60, 1'b0);
      run_phase(1'b0, 1'b1, TYPE_TEXT, 32'd40, 32'd100, 24, 60, 1'b0);
      run_phase(1'b1, 1'b1, TYPE_BINARY, 32'd0, 32'd0, 60, 24, 1'b0);
      run_phase(1'b0, 1'b0, TYPE_UNCHECKED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 24, 1'b0);
      run_phase(1'b1, 1'b1, TYPE_ANY, 32'd300, 32'd600, 0, 0, 1'b1);

      // Last, a frame whose 64-bit length has the top bit set: with limits
      // off it is valid, saturates the message count and never ends, so its
      // first payload bytes simply stream through.
      quiesce();
      write_registers(1'b1, 1'b0, TYPE_BINARY, 32'd0, 32'd0);
      close_open_message();
      send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 64'h8000_0000_0000_0005, LEN_EXT64, 40);

      quiesce();
      $display("Sent %0d bytes in %0d frames under %0d register settings, with a long",
               bytes_sent, frames_sent, settings_used);
      $display("result-side hold-off; %0d results compared, %0d mismatches",
               results_checked, mismatch_count);
      if (mismatch_count == 0 && items_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
